// ===== sv/bmp_rle8_decoder_macros.svh =====
// Assertion macros shared by the BMP RLE8 decoder modules.
`ifndef BMP_RLE8_DECODER_MACROS_SVH
`define BMP_RLE8_DECODER_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define BMPR_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define BMPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bmpr_pkg.sv =====
// Types, constants and codes shared by the BMP RLE8 decoder modules.
`default_nettype none

package bmpr_pkg;

	// Width of a saturated image dimension (covers up to 8192).
	localparam int DIM_W = 14;
	// Width of the configuration registers.
	localparam int CFG_W = 13;
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int CMDQ_DEPTH = 4;
	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 12;

	// Configuration register indexes.
	localparam logic [0:0] CFG_IMAGE_WIDTH = 1'b0;
	localparam logic [0:0] CFG_IMAGE_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 13'd256;

	// Escape codes that follow a zero count byte.
	localparam logic [7:0] ESC_EOL = 8'd0;
	localparam logic [7:0] ESC_EOB = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_VALUE,
		PH_DX,
		PH_DY,
		PH_LIT,
		PH_PAD
	} phase_t;

	typedef enum logic [2:0] {
		CMD_START,
		CMD_PAINT,
		CMD_EOL,
		CMD_STOP,
		CMD_DX,
		CMD_DY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       len;
		logic [7:0]       val;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WRAP,
		BK_PAINT
	} back_state_t;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] column;
		logic [7:0]           length;
		logic [7:0]           color;
		logic                 last;
	} span_t;

	// Queue status seen by the back end.
	typedef struct packed {
		logic avail;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

// ===== sv/bmp_rle8_decoder.sv =====
// Top level of the BMP RLE8 decoder: parser, command queue and span generator.
//
//   channel   handshake           payload
//   input     push / full         data_byte, image_start
//   result    empty / pop         span_row, span_column, span_length, color_index, last_span
//   config    cfg_write           cfg_index, cfg_data
//
// The parser takes one byte per cycle while the command queue has room.
// The span generator takes each command in its idle state and emits the spans of a run in its
// paint state, split at the row end; a column at or past the width is first folded back row by
// row in the wrap state.
// A full result register stalls the span generator; a full queue raises full.
// Reset is asynchronous; the decoder is ready in the cycle after it is released.
`default_nettype none

module bmp_rle8_decoder
	import bmpr_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output      logic                 full,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 image_start,
	output      logic                 empty,
	input  wire logic                 pop,
	output      logic [OUT_ROW_W-1:0] span_row,
	output      logic [OUT_COL_W-1:0] span_column,
	output      logic [7:0]           span_length,
	output      logic [7:0]           color_index,
	output      logic                 last_span,
	input  wire logic                 cfg_write,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	q_status_t q_status;
	logic      accept;
	logic      cmd_push;
	cmd_t      cmd_in;
	cmd_t      cmd_out;
	logic      cmd_pop;
	logic      out_valid;
	span_t     span;

	assign full = q_status.full;
	assign accept = push && !q_status.full;

	bmpr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (data_byte),
		.image_start(image_start),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	bmpr_cmdq #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.pop   (cmd_pop),
		.status(q_status),
		.rdata (cmd_out)
	);

	bmpr_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.pop      (pop),
		.out_valid(out_valid),
		.span     (span)
	);

	// Drive the result ports from the span register.
	assign empty = !out_valid;
	assign span_row = span.row;
	assign span_column = span.column;
	assign span_length = span.length;
	assign color_index = span.color;
	assign last_span = span.last;

endmodule

`default_nettype wire

// ===== sv/bmpr_front.sv =====
// Front end: configuration registers and byte parser that issues commands.
`default_nettype none

module bmpr_front
	import bmpr_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             image_start,
	output      logic             cmd_push,
	output      cmd_t             cmd
);

	localparam logic [DIM_W-1:0] MAX_W_L = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_L = DIM_W'(MAX_HEIGHT);
	localparam logic [DIM_W-1:0] MIN_W_L = DIM_W'(8);
	localparam logic [DIM_W-1:0] MIN_H_L = DIM_W'(1);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	phase_t           phase_q;
	phase_t           phase_d;
	phase_t           ph_cur;
	logic [7:0]       run_q;
	logic [7:0]       run_d;
	logic [7:0]       lit_q;
	logic [7:0]       lit_d;
	logic [7:0]       lit_next;
	logic             pad_q;
	logic             pad_d;
	logic [DIM_W-1:0] w_ext;
	logic [DIM_W-1:0] h_ext;
	logic [DIM_W-1:0] eff_w;
	logic [DIM_W-1:0] eff_h;

	// Hold the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_DIM_RESET;
			height_q <= CFG_DIM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q <= width_q;
			endcase
		end
	end

	// Clamp the dimensions into their legal ranges.
	always_comb begin
		w_ext = DIM_W'(width_q);
		h_ext = DIM_W'(height_q);
		eff_w = (w_ext < MIN_W_L) ? MIN_W_L : ((w_ext > MAX_W_L) ? MAX_W_L : w_ext);
		eff_h = (h_ext < MIN_H_L) ? MIN_H_L : ((h_ext > MAX_H_L) ? MAX_H_L : h_ext);
	end

	// A new image restarts parsing at a count byte.
	assign ph_cur = image_start ? PH_COUNT : phase_q;
	assign lit_next = (lit_q != 8'd0) ? (lit_q - 8'd1) : 8'd0;

	// Advance the parse phase.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (ph_cur)
				PH_COUNT: phase_d = PH_VALUE;
				PH_VALUE: begin
					if (run_q != 8'd0) begin
						phase_d = PH_COUNT;
					end else begin
						unique case (data_byte)
							ESC_EOL:   phase_d = PH_COUNT;
							ESC_EOB:   phase_d = PH_COUNT;
							ESC_DELTA: phase_d = PH_DX;
							default:   phase_d = PH_LIT;
						endcase
					end
				end
				PH_DX:    phase_d = PH_DY;
				PH_DY:    phase_d = PH_COUNT;
				PH_LIT: begin
					if (lit_next == 8'd0) begin
						phase_d = pad_q ? PH_PAD : PH_COUNT;
					end
				end
				PH_PAD:   phase_d = PH_COUNT;
				default:  phase_d = PH_COUNT;
			endcase
		end
	end

	// Classify the byte and build its command.
	always_comb begin
		run_d = run_q;
		lit_d = lit_q;
		pad_d = pad_q;
		cmd_push = 1'b0;
		cmd.kind = CMD_PAINT;
		cmd.len = 8'd1;
		cmd.val = data_byte;
		cmd.width = eff_w;
		cmd.height = eff_h;
		if (accept) begin
			if (image_start) begin
				cmd_push = 1'b1;
				cmd.kind = CMD_START;
			end
			unique case (ph_cur)
				PH_COUNT: run_d = data_byte;
				PH_VALUE: begin
					if (run_q != 8'd0) begin
						cmd_push = 1'b1;
						cmd.kind = CMD_PAINT;
						cmd.len = run_q;
					end else begin
						unique case (data_byte)
							ESC_EOL: begin
								cmd_push = 1'b1;
								cmd.kind = CMD_EOL;
							end
							ESC_EOB: begin
								cmd_push = 1'b1;
								cmd.kind = CMD_STOP;
							end
							ESC_DELTA: begin
								cmd_push = 1'b0;
							end
							default: begin
								lit_d = data_byte;
								pad_d = data_byte[0];
							end
						endcase
					end
				end
				PH_DX: begin
					cmd_push = 1'b1;
					cmd.kind = CMD_DX;
				end
				PH_DY: begin
					cmd_push = 1'b1;
					cmd.kind = CMD_DY;
				end
				PH_LIT: begin
					cmd_push = 1'b1;
					cmd.kind = CMD_PAINT;
					cmd.len = 8'd1;
					lit_d = lit_next;
				end
				PH_PAD:   pad_d = 1'b0;
				default:  pad_d = 1'b0;
			endcase
		end
	end

	// Hold the parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			run_q <= 8'd0;
			lit_q <= 8'd0;
			pad_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			run_q <= run_d;
			lit_q <= lit_d;
			pad_q <= pad_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/bmpr_cmdq.sv =====
// Command queue between the parser and the span generator.
`default_nettype none
`include "bmp_rle8_decoder_macros.svh"

module bmpr_cmdq
	import bmpr_pkg::*;
#(
	parameter int DEPTH = CMDQ_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output      q_status_t status,
	output      cmd_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_L = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_L = AW'(DEPTH - 1);

	cmd_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign status.full = (count_q == DEPTH_L);
	assign status.avail = (count_q != '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && status.avail;
	assign rdata = entry_q[rd_ptr_q];

	// Store the incoming command.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance the pointers and the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_L) ? '0 : (wr_ptr_q + AW'(1));
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_L) ? '0 : (rd_ptr_q + AW'(1));
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`BMPR_ASSERT(a_no_push_when_full, push, !status.full, "command pushed into a full queue")
	`BMPR_ASSERT_NEXT(a_push_lands, push && !pop, status.avail, "pushed command not visible")
	`BMPR_ASSERT(a_count_bound, 1'b1, count_q <= DEPTH_L, "fill count out of range")

endmodule

`default_nettype wire

// ===== sv/bmpr_back.sv =====
// Back end: position tracking, row wrapping and span output register.
`default_nettype none
`include "bmp_rle8_decoder_macros.svh"

module bmpr_back
	import bmpr_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire q_status_t q_status,
	input  wire cmd_t      cmd,
	output      logic      cmd_pop,
	input  wire logic      pop,
	output      logic      out_valid,
	output      span_t     span
);

	localparam int CB = $clog2(MAX_WIDTH + 256);
	localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW = DIM_W + 1;
	localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
	localparam logic [RB-1:0] ROW_RST = RB'(RST_H - 1);

	back_state_t      state_q;
	back_state_t      state_d;
	logic [CB-1:0]    col_q;
	logic [CB-1:0]    col_d;
	logic [RB-1:0]    row_q;
	logic [RB-1:0]    row_d;
	logic             wrapped_q;
	logic             wrapped_d;
	logic             done_q;
	logic             done_d;
	logic             pend_q;
	logic             pend_d;
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] w_d;
	logic [7:0]       left_q;
	logic [7:0]       left_d;
	logic [7:0]       color_q;
	logic [7:0]       color_d;
	span_t            out_q;
	logic             out_valid_q;
	logic             out_ld;
	logic             out_free;
	logic [XW-1:0]    col_x;
	logic [XW-1:0]    w_x;
	logic [XW-1:0]    cw_x;
	logic [XW-1:0]    dx_sum;
	logic [XW-1:0]    room;
	logic             dx_wrap;
	logic             paint_wrap;
	logic             wrap_need;
	logic             row_zero;
	logic             dy_over;
	logic             room_le;
	logic [7:0]       take;
	logic             span_last;
	logic             cmd_live;

	// Shared compares on the position.
	always_comb begin
		col_x = XW'(col_q);
		w_x = XW'(w_q);
		cw_x = XW'(cmd.width);
		dx_sum = col_x + XW'(cmd.val);
		dx_wrap = (dx_sum >= cw_x);
		paint_wrap = (col_x >= cw_x);
		wrap_need = (col_x >= w_x);
		row_zero = (row_q == '0);
		dy_over = (XW'(cmd.val) > XW'(row_q));
		room = w_x - col_x;
		room_le = (room <= XW'(left_q));
		take = room_le ? 8'(room) : left_q;
		span_last = (take == left_q) || (room_le && row_zero);
		out_free = !out_valid_q || pop;
		cmd_live = q_status.avail && !done_q && (cmd.kind != CMD_START);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_live && (cmd.kind == CMD_DX) && dx_wrap) begin
					state_d = BK_WRAP;
				end else if (cmd_live && (cmd.kind == CMD_PAINT)) begin
					state_d = paint_wrap ? BK_WRAP : BK_PAINT;
				end
			end
			BK_WRAP: begin
				if (wrap_need) begin
					state_d = row_zero ? BK_IDLE : BK_WRAP;
				end else begin
					state_d = pend_q ? BK_PAINT : BK_IDLE;
				end
			end
			BK_PAINT: begin
				if (out_free && span_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Position updates and span generation.
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		wrapped_d = wrapped_q;
		done_d = done_q;
		pend_d = pend_q;
		w_d = w_q;
		left_d = left_q;
		color_d = color_q;
		cmd_pop = 1'b0;
		out_ld = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				cmd_pop = q_status.avail;
				if (q_status.avail && (cmd.kind == CMD_START)) begin
					col_d = '0;
					row_d = RB'(cmd.height - DIM_W'(1));
					wrapped_d = 1'b0;
					done_d = 1'b0;
				end else if (cmd_live) begin
					case (cmd.kind)
						CMD_EOL: begin
							if (!wrapped_q) begin
								col_d = '0;
								if (row_zero) begin
									done_d = 1'b1;
								end else begin
									row_d = row_q - RB'(1);
								end
							end
						end
						CMD_STOP: done_d = 1'b1;
						CMD_DX: begin
							col_d = CB'(dx_sum);
							w_d = cmd.width;
							pend_d = 1'b0;
						end
						CMD_DY: begin
							if (dy_over) begin
								done_d = 1'b1;
							end else begin
								row_d = row_q - RB'(cmd.val);
							end
						end
						CMD_PAINT: begin
							w_d = cmd.width;
							left_d = cmd.len;
							color_d = cmd.val;
							pend_d = 1'b1;
						end
						default: done_d = done_q;
					endcase
				end
			end
			BK_WRAP: begin
				// Fold the column back one row per cycle.
				if (wrap_need) begin
					col_d = CB'(col_x - w_x);
					if (row_zero) begin
						done_d = 1'b1;
					end else begin
						row_d = row_q - RB'(1);
					end
				end
			end
			BK_PAINT: begin
				// Emit one span, split at the row end.
				if (out_free) begin
					out_ld = 1'b1;
					left_d = left_q - take;
					wrapped_d = room_le;
					if (room_le) begin
						col_d = '0;
						if (row_zero) begin
							done_d = 1'b1;
						end else begin
							row_d = row_q - RB'(1);
						end
					end else begin
						col_d = CB'(col_x + XW'(take));
					end
				end
			end
			default: done_d = done_q;
		endcase
	end

	// Hold the control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			col_q <= '0;
			row_q <= ROW_RST;
			wrapped_q <= 1'b0;
			done_q <= 1'b0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
			row_q <= row_d;
			wrapped_q <= wrapped_d;
			done_q <= done_d;
			pend_q <= pend_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the run payload and the span register.
	always_ff @(posedge clk) begin
		w_q <= w_d;
		left_q <= left_d;
		color_q <= color_d;
		if (out_ld) begin
			out_q.row <= OUT_ROW_W'(row_q);
			out_q.column <= OUT_COL_W'(col_q);
			out_q.length <= take;
			out_q.color <= color_q;
			out_q.last <= span_last;
		end
	end

	assign out_valid = out_valid_q;
	assign span = out_q;

	`BMPR_ASSERT(a_out_no_overwrite, out_ld, out_free, "span register overwritten")
	`BMPR_ASSERT(a_span_fits_row, out_ld, (take != 8'd0) && ((col_x + XW'(take)) <= w_x), "span leaves the row")
	`BMPR_ASSERT(a_busy_not_done, (state_q == BK_WRAP) || (state_q == BK_PAINT), !done_q, "working after the stream ended")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the BMP RLE8 decoder: span prediction, queue handshakes, checks.
`timescale 1ns / 100ps

import bmpr_pkg::*;

// Tracks the decoder state and the spans that the accepted stream bytes must paint.
class span_tracker;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	phase_t           phase;
	logic [7:0]       run_len;
	logic [7:0]       lits_left;
	bit               pad_due;
	bit               wrapped;
	bit               halted;
	int               col;
	int               row;
	int               made;
	span_t            spans_due[$];

	function new();
		width_reg = CFG_DIM_RESET;
		height_reg = CFG_DIM_RESET;
		restart();
	endfunction

	function int eff_width();
		if (width_reg < 8) return 8;
		if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return int'(width_reg);
	endfunction

	function int eff_height();
		if (height_reg < 1) return 1;
		if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
		return int'(height_reg);
	endfunction

	function void restart();
		phase = PH_COUNT;
		run_len = '0;
		lits_left = '0;
		pad_due = 1'b0;
		col = 0;
		row = eff_height() - 1;
		wrapped = 1'b0;
		halted = 1'b0;
	endfunction

	function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
		if (idx == CFG_IMAGE_WIDTH) width_reg = val;
		else height_reg = val;
	endfunction

	// Stop the image once the row runs off the top.
	function void clip_row();
		if (row < 0) begin
			row = -1;
			halted = 1'b1;
		end
	endfunction

	// Fold a column at or past the width into the rows above.
	function void fold_column(int w);
		while (col >= w) begin
			col -= w;
			row--;
		end
		clip_row();
	endfunction

	// Split len pixels of one color into spans at row ends.
	function void paint(int len, logic [7:0] color);
		int    w;
		int    left;
		int    take;
		span_t s;
		w = eff_width();
		left = len;
		fold_column(w);
		while (left > 0 && !halted) begin
			take = w - col;
			if (take > left) take = left;
			s.row = OUT_ROW_W'(row);
			s.column = OUT_COL_W'(col);
			s.length = 8'(take);
			s.color = color;
			s.last = 1'b0;
			spans_due.push_back(s);
			made++;
			col += take;
			left -= take;
			if (col >= w) begin
				col = 0;
				row--;
				wrapped = 1'b1;
				clip_row();
			end else begin
				wrapped = 1'b0;
			end
		end
	endfunction

	// Note one accepted stream byte; returns 0 when the byte is ignored.
	function bit take_byte(logic [7:0] b, logic st);
		span_t tail;
		if (st) restart();
		if (halted) return 1'b0;
		made = 0;
		case (phase)
			PH_COUNT: begin
				run_len = b;
				phase = PH_VALUE;
			end
			PH_VALUE: begin
				phase = PH_COUNT;
				if (run_len != 0) begin
					paint(int'(run_len), b);
				end else if (b == ESC_EOL) begin
					// a row end right after a wrap is already done
					if (!wrapped) begin
						col = 0;
						row--;
						clip_row();
					end
				end else if (b == ESC_EOB) begin
					halted = 1'b1;
				end else if (b == ESC_DELTA) begin
					phase = PH_DX;
				end else begin
					lits_left = b;
					pad_due = b[0];
					phase = PH_LIT;
				end
			end
			PH_DX: begin
				col += int'(b);
				fold_column(eff_width());
				phase = PH_DY;
			end
			PH_DY: begin
				row -= int'(b);
				clip_row();
				phase = PH_COUNT;
			end
			PH_LIT: begin
				paint(1, b);
				if (lits_left > 0) lits_left--;
				if (lits_left == 0) phase = pad_due ? PH_PAD : PH_COUNT;
			end
			default: begin
				pad_due = 1'b0;
				phase = PH_COUNT;
			end
		endcase
		// mark the final span of this byte
		if (made > 0) begin
			tail = spans_due.pop_back();
			tail.last = 1'b1;
			spans_due.push_back(tail);
		end
		return 1'b1;
	endfunction

	function int pending();
		return spans_due.size();
	endfunction

	// Compare one popped span with the oldest expected one; empty string when equal.
	function string check_span(logic [OUT_ROW_W-1:0] r, logic [OUT_COL_W-1:0] c,
			logic [7:0] len, logic [7:0] color, logic last);
		string msg;
		span_t want;
		if (spans_due.size() == 0)
			return $sformatf("unexpected span row %0d col %0d len %0d color %0d last %0b",
				r, c, len, color, last);
		want = spans_due.pop_front();
		msg = "";
		if (r !== want.row) msg = {msg, $sformatf(" row %0d/%0d", r, want.row)};
		if (c !== want.column) msg = {msg, $sformatf(" col %0d/%0d", c, want.column)};
		if (len !== want.length) msg = {msg, $sformatf(" len %0d/%0d", len, want.length)};
		if (color !== want.color) msg = {msg, $sformatf(" color %0d/%0d", color, want.color)};
		if (last !== want.last) msg = {msg, $sformatf(" last %0b/%0b", last, want.last)};
		if (msg != "") msg = {"span mismatch (got/expected):", msg};
		return msg;
	endfunction
endclass

module tb;
	localparam logic [7:0] RLE_ESCAPE = 8'h00;
	localparam int TOTAL_BYTES = 280;
	localparam int SETTLE_CYCLES = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [7:0]           data_byte = '0;
	logic                 image_start = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [OUT_ROW_W-1:0] span_row;
	logic [OUT_COL_W-1:0] span_column;
	logic [7:0]           span_length;
	logic [7:0]           color_index;
	logic                 last_span;
	logic                 cfg_write = 1'b0;
	logic [0:0]           cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	span_tracker tracker;
	int          errors = 0;
	int          sent_bytes = 0;
	int          stalled_cycles = 0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;
	bit          hold_results = 1'b0;

	bmp_rle8_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.image_start(image_start),
		.empty(empty),
		.pop(pop),
		.span_row(span_row),
		.span_column(span_column),
		.span_length(span_length),
		.color_index(color_index),
		.last_span(last_span),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
	endtask

	// Offer one byte after a random gap; hold it until the decoder takes the beat.
	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		image_start <= st;
		do @(posedge clk); while (full);
		sent_bytes++;
		void'(tracker.take_byte(b, st));
	endtask

	task automatic send_run(input logic st, input logic [7:0] n, input logic [7:0] color);
		send_byte(n, st);
		send_byte(color, 1'b0);
	endtask

	task automatic send_eol(input logic st);
		send_byte(RLE_ESCAPE, st);
		send_byte(ESC_EOL, 1'b0);
	endtask

	task automatic send_eob(input logic st);
		send_byte(RLE_ESCAPE, st);
		send_byte(ESC_EOB, 1'b0);
	endtask

	task automatic send_delta(input logic st, input logic [7:0] dx, input logic [7:0] dy);
		send_byte(RLE_ESCAPE, st);
		send_byte(ESC_DELTA, 1'b0);
		send_byte(dx, 1'b0);
		send_byte(dy, 1'b0);
	endtask

	// Absolute run of n literal pixels, padded to a word when n is odd.
	task automatic send_absolute(input logic st, input logic [7:0] n);
		send_byte(RLE_ESCAPE, st);
		send_byte(n, 1'b0);
		for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
		if (n[0]) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Stop offering bytes, wait for every expected span, then let the back end settle.
	task automatic drain();
		push <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write width and/or height while the decoder is idle.
	task automatic set_dims(input bit do_w, input logic [CFG_W-1:0] w,
			input bit do_h, input logic [CFG_W-1:0] h);
		if (do_w) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IMAGE_WIDTH;
			cfg_data <= w;
			@(posedge clk);
			tracker.write_reg(CFG_IMAGE_WIDTH, w);
		end
		if (do_h) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IMAGE_HEIGHT;
			cfg_data <= h;
			@(posedge clk);
			tracker.write_reg(CFG_IMAGE_HEIGHT, h);
		end
		cfg_write <= 1'b0;
	endtask

	// Check every span beat against the oldest expectation.
	always @(posedge clk) begin
		string msg;
		if (arst_n && pop && !empty) begin
			msg = tracker.check_span(span_row, span_column, span_length, color_index, last_span);
			if (msg != "") flag_error(msg);
		end
	end

	// End the run when no beat moves on either side for too long.
	initial begin
		wait (arst_n === 1'b1);
		while (stalled_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) stalled_cycles = 0;
			else stalled_cycles++;
		end
		$display("FAIL bmp_rle8_decoder");
		$finish;
	end

	// Result side: random pop gaps, plus one long hold-off on request.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			gap = rx_steady ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	initial begin
		logic [CFG_W-1:0] corner_w[4] = '{13'd0, 13'd8191, 13'd8, 13'd4096};
		logic [CFG_W-1:0] corner_h[4] = '{13'd0, 13'd4096, 13'd1, 13'd8191};
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		int               phase_no;
		int               goal;
		int               sel;
		bit               fresh;
		bit               st;

		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: longest run from column 4, row ends, deltas, absolute run.
		set_dims(1'b1, 13'd0, 1'b1, 13'd8191);
		send_delta(1'b1, 8'd4, 8'd0);
		send_run(1'b0, 8'd255, 8'hFF);
		send_eol(1'b0);
		send_run(1'b0, 8'd8, 8'h00);
		// row end right after a wrap does nothing
		send_eol(1'b0);
		send_delta(1'b0, 8'd20, 8'd1);
		send_absolute(1'b0, 8'd3);
		drain();

		// Narrow the width under a column far to the right.
		set_dims(1'b1, 13'd8191, 1'b0, '0);
		send_delta(1'b0, 8'd200, 8'd0);
		drain();
		set_dims(1'b1, 13'd100, 1'b0, '0);
		send_run(1'b0, 8'd3, 8'h44);
		drain();

		// Run off the top row, then end of bitmap; trailing bytes are dropped.
		set_dims(1'b0, '0, 1'b1, 13'd1);
		send_run(1'b1, 8'd3, 8'h07);
		send_eol(1'b0);
		send_run(1'b0, 8'd5, 8'h09);
		send_eob(1'b1);
		send_run(1'b0, 8'd2, 8'h02);
		drain();

		// Back-pressure: hold pops while long runs fill the decoder.
		set_dims(1'b1, 13'd8, 1'b1, 13'd4096);
		tx_steady = 1'b1;
		hold_results = 1'b1;
		for (int i = 0; i < 6; i++)
			send_run(i == 0, 8'd255, 8'($urandom_range(0, 255)));
		drain();

		// Random phases of well-formed commands with some broken pairing and restarts.
		for (phase_no = 0; sent_bytes < TOTAL_BYTES; phase_no++) begin
			if (phase_no < 4) begin
				w = corner_w[phase_no];
				h = corner_h[phase_no];
			end else begin
				w = ($urandom_range(0, 2) == 0) ? 13'($urandom_range(0, 8191))
					: 13'($urandom_range(8, 40));
				h = ($urandom_range(0, 2) == 0) ? 13'($urandom_range(0, 8191))
					: 13'($urandom_range(1, 40));
			end
			set_dims(1'b1, w, phase_no < 4 || $urandom_range(0, 1) == 1, h);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			fresh = (phase_no < 4) || ($urandom_range(0, 3) != 0);
			goal = sent_bytes + 40;
			while (sent_bytes < goal) begin
				st = fresh || tracker.halted;
				fresh = 1'b0;
				sel = $urandom_range(0, 99);
				if (sel < 40)
					send_run(st, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
						: 8'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
				else if (sel < 55)
					send_eol(st);
				else if (sel < 67)
					send_delta(st,
						($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(0, 10)),
						($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(0, 2)));
				else if (sel < 85)
					send_absolute(st, ($urandom_range(0, 19) == 0) ? 8'($urandom_range(3, 64))
						: 8'($urandom_range(3, 12)));
				else if (sel < 90)
					send_eob(st);
				else if (sel < 95)
					send_byte(8'($urandom_range(0, 255)), st);
				else
					send_byte(8'($urandom_range(0, 255)), 1'b1);
			end
			drain();
		end

		if (errors == 0) $display("PASS bmp_rle8_decoder");
		else $display("FAIL bmp_rle8_decoder");
		$finish;
	end
endmodule

// ===== bmp_rle8_decoder.f =====
+incdir+sv
sv/bmpr_pkg.sv
sv/bmpr_front.sv
sv/bmpr_cmdq.sv
sv/bmpr_back.sv
sv/bmp_rle8_decoder.sv
tb/sv/tb.sv
